// ----- sv/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared constants and types for the wildcard star pattern match unit.
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int ROW_W       = PATTERN_MAX + 1;
    localparam int ROW_IDX_W   = $clog2(ROW_W);
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_APPEND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    // Item broadcast to every cell of the row
    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] text_byte;
    } wsm_ctl_t;

    // What one cell hands to its neighbors: its stored flag and its new flag
    typedef struct packed {
        logic old_bit;
        logic new_bit;
    } wsm_link_t;

endpackage

// ----- sv/wsm_cell.sv -----
// ----------------------------------------------------------------------------
// wsm_cell
// One pattern position: holds one match flag of the row and computes its
// next value from the neighbor flags.
// ----------------------------------------------------------------------------
module wsm_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       is_first,
    input  wsm_pkg::wsm_ctl_t          ctl,
    input  logic [wsm_pkg::BYTE_W-1:0] pat_byte,
    input  logic [wsm_pkg::BYTE_W-1:0] prev_byte,
    input  wsm_pkg::wsm_link_t         link_m1,
    input  wsm_pkg::wsm_link_t         link_m2,
    output wsm_pkg::wsm_link_t         link_out
);

    logic row_bit_reg;
    logic row_bit_next;
    logic lit_hit;
    logic prev_hit;
    logic is_star;

    always_comb begin
        lit_hit  = (ctl.text_byte == pat_byte) || (pat_byte == wsm_pkg::DOT_BYTE);
        prev_hit = (ctl.text_byte == prev_byte) || (prev_byte == wsm_pkg::DOT_BYTE);
        is_star  = (pat_byte == wsm_pkg::STAR_BYTE) && !is_first;
        if (ctl.func == wsm_pkg::FUNC_START) begin
            // empty text: a star carries the flag two positions back
            row_bit_next = is_star && link_m2.new_bit;
        end else if (lit_hit) begin
            row_bit_next = link_m1.old_bit;
        end else if (is_star) begin
            row_bit_next = link_m2.new_bit
                         | (prev_hit & (row_bit_reg | link_m2.old_bit));
        end else begin
            row_bit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bit_reg <= 1'b0;
        end else if (advance) begin
            row_bit_reg <= row_bit_next;
        end
    end

    assign link_out.old_bit = row_bit_reg;
    assign link_out.new_bit = row_bit_next;

endmodule

// ----- sv/wildcard_star_pattern_match_unit.sv -----
// ----------------------------------------------------------------------------
// wildcard_star_pattern_match_unit
// Streams text bytes against a configured pattern with '.' and '*' and
// reports after every item whether the whole text matches the whole pattern.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake         payload
//   s_       in         s_valid/s_ready   s_func, s_text_byte
//   m_       out        m_valid/m_ready   m_matched
//   cfg_     in         cfg_we            cfg_index, cfg_data
//
// One item per cycle: the row of match flags lives in a chain of cells, one
// per pattern position, and each accepted item updates the whole row in the
// cycle it is accepted; the result is registered and shows in the cycle after.
// Reset is synchronous and active low; it loads the row with only bit zero set
// and clears the pattern registers. An item is accepted whenever the output
// register is empty or is drained in the same cycle, so a stall on m_ only
// backs up s_ once the single result register is full.
// ----------------------------------------------------------------------------
module wildcard_star_pattern_match_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [wsm_pkg::BYTE_W-1:0]     s_text_byte,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_matched
);

    localparam int PM = wsm_pkg::PATTERN_MAX;
    localparam int BW = wsm_pkg::BYTE_W;
    localparam int BPW = wsm_pkg::BYTES_PER_WORD;

    // configuration registers
    logic [wsm_pkg::LEN_W-1:0]      pattern_length_reg;
    logic [wsm_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [wsm_pkg::CFG_DATA_W-1:0] pattern_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wsm_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[wsm_pkg::LEN_W-1:0];
                wsm_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                wsm_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // split the pattern words into bytes, byte 0 in the low word's low bits
    logic [BW-1:0] pat_bytes [0:PM-1];

    always_comb begin
        for (int k = 0; k < PM; k++) begin
            if (k < BPW) begin
                pat_bytes[k] = pattern_low_reg[(k % BPW)*BW +: BW];
            end else begin
                pat_bytes[k] = pattern_high_reg[(k % BPW)*BW +: BW];
            end
        end
    end

    // handshake: advance the row on every accepted item
    logic advance;
    logic m_valid_reg;
    logic m_valid_next;
    logic m_matched_reg;
    logic m_matched_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign advance = s_valid && s_ready;

    wsm_pkg::wsm_ctl_t ctl;
    assign ctl.func      = s_func;
    assign ctl.text_byte = s_text_byte;

    // position zero: set for the empty text, clear once any byte is appended
    logic row0_reg;
    logic row0_next;

    assign row0_next = (s_func == wsm_pkg::FUNC_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg <= 1'b1;
        end else if (advance) begin
            row0_reg <= row0_next;
        end
    end

    // chain of cells, one per pattern position
    wsm_pkg::wsm_link_t links [0:PM];
    wsm_pkg::wsm_link_t no_link;

    assign links[0].old_bit = row0_reg;
    assign links[0].new_bit = row0_next;
    assign no_link          = '0;

    for (genvar j = 1; j <= PM; j++) begin : g_cell
        if (j == 1) begin : g_first
            wsm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .is_first  (1'b1),
                .ctl       (ctl),
                .pat_byte  (pat_bytes[j-1]),
                .prev_byte (pat_bytes[j-1]),
                .link_m1   (links[j-1]),
                .link_m2   (no_link),
                .link_out  (links[j])
            );
        end else begin : g_rest
            wsm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .is_first  (1'b0),
                .ctl       (ctl),
                .pat_byte  (pat_bytes[j-1]),
                .prev_byte (pat_bytes[j-2]),
                .link_m1   (links[j-1]),
                .link_m2   (links[j-2]),
                .link_out  (links[j])
            );
        end
    end

    // pick the flag at the configured length, clamped to the row
    logic [wsm_pkg::ROW_W-1:0]     row_next;
    logic [wsm_pkg::ROW_IDX_W-1:0] len_sel;

    always_comb begin
        for (int j = 0; j <= PM; j++) begin
            row_next[j] = links[j].new_bit;
        end
        if (pattern_length_reg > wsm_pkg::LEN_W'(PM)) begin
            len_sel = wsm_pkg::ROW_IDX_W'(PM);
        end else begin
            len_sel = wsm_pkg::ROW_IDX_W'(pattern_length_reg);
        end
    end

    // output register: load on accept, hold while stalled, drop when taken
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_matched_next = m_matched_reg;
        if (advance) begin
            m_valid_next   = 1'b1;
            m_matched_next = row_next[len_sel];
        end else if (m_ready) begin
            m_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg <= m_matched_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wildcard star pattern match unit: a directed
// table of patterns and texts, then random start/append sequences under four
// idling modes, each result checked in order against an in-bench row model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsm_pkg::*;

    localparam int ITEMS_PER_SETTING = 150;
    localparam int SETTINGS_PER_MODE = 3;
    localparam int HOLD_CYCLES       = 300;
    // index 3 is not a register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {WANT_NO, WANT_YES, WANT_PRED} want_t;
    typedef enum logic {ROW_ITEM, ROW_LOAD} row_kind_t;

    // one line of the directed table: either a pattern load or one item
    typedef struct packed {
        row_kind_t             kind;
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic                  item_func;
        logic [BYTE_W-1:0]     text;
        want_t                 want;
    } dir_row_t;

    // clock, reset and every block input start at known values
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_func      = FUNC_START;
    logic [BYTE_W-1:0]     s_text_byte = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_matched;

    // shadow of the pattern registers and of the row of match flags
    logic [LEN_W-1:0]      pat_len     = '0;
    logic [CFG_DATA_W-1:0] pat_lo      = '0;
    logic [CFG_DATA_W-1:0] pat_hi      = '0;
    logic [ROW_W-1:0]      match_flags = ROW_W'(1);

    logic pending_match_q[$];
    logic oldest_match;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int matches_seen  = 0;
    int settings_done = 0;

    dir_row_t dir_tab [32];

    wildcard_star_pattern_match_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_text_byte (s_text_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_matched   (m_matched)
    );

    always #5 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
        if (k < BYTES_PER_WORD) begin
            return pat_lo[BYTE_W*k +: BYTE_W];
        end
        return pat_hi[BYTE_W*(k - BYTES_PER_WORD) +: BYTE_W];
    endfunction

    // lengths above the pattern size act as the full pattern
    function automatic int effective_length();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    // Row of match flags after one item: bit j set when the text so far
    // matches the first j pattern bytes.
    function automatic logic [ROW_W-1:0] next_match_flags(
        input logic [ROW_W-1:0]  prev_row,
        input logic              item_func,
        input logic [BYTE_W-1:0] text
    );
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] pc;
        logic [BYTE_W-1:0] lead;
        row = '0;
        if (item_func == FUNC_START) begin
            // empty text: bit 0, plus every "x*" pair chained from it
            row[0] = 1'b1;
            for (int j = 2; j <= PATTERN_MAX; j++)
                if (pattern_byte(j - 1) == STAR_BYTE && row[j - 2]) row[j] = 1'b1;
        end else begin
            for (int j = 1; j <= PATTERN_MAX; j++) begin
                pc = pattern_byte(j - 1);
                if (text == pc || pc == DOT_BYTE) begin
                    // literal compare goes first, even against a '*'
                    row[j] = prev_row[j - 1];
                end else if (pc == STAR_BYTE && j >= 2) begin
                    // zero copies from the new row, one more copy from the old
                    lead   = pattern_byte(j - 2);
                    row[j] = row[j - 2];
                    if (text == lead || lead == DOT_BYTE)
                        row[j] = row[j] | prev_row[j] | prev_row[j - 2];
                end
                // a '*' in the first position without a literal hit stays 0
            end
        end
        return row;
    endfunction

    // Offer one item after a random gap, hold it until accepted, then
    // record the result it must produce. Returns at the next falling edge.
    task automatic send_item(
        input logic              item_func,
        input logic [BYTE_W-1:0] text,
        input want_t             want
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= item_func;
        s_text_byte <= text;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: advance the shadow row now
        match_flags = next_match_flags(match_flags, item_func, text);
        if (want == WANT_PRED) begin
            pending_match_q.push_back(match_flags[effective_length()]);
        end else begin
            pending_match_q.push_back(want == WANT_YES);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait for every pending result; returns at a falling edge.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_match_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Program all pattern registers, plus a junk write to the spare index.
    // Only call while the block is idle.
    task automatic set_pattern(
        input logic [LEN_W-1:0]      len,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [CFG_DATA_W-1:0] len_word;
        // upper bits of the length word are don't-care; fill them with noise
        len_word            = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= len_word;
        @(negedge aclk);
        cfg_index <= CFG_PATTERN_LOW;
        cfg_data  <= lo;
        @(negedge aclk);
        cfg_index <= CFG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(negedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= {$urandom, $urandom};
        @(negedge aclk);
        cfg_we <= 1'b0;
        pat_len = len;
        pat_lo  = lo;
        pat_hi  = hi;
        settings_done++;
    endtask

    // Receiver: a long hold-off when requested, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result against the oldest pending one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_matched === 1'b1) matches_seen++;
            if (pending_match_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, got matched=%0b",
                         $time, m_matched);
            end else begin
                oldest_match = pending_match_q.pop_front();
                if (m_matched !== oldest_match) begin
                    errors++;
                    $display("%0t: matched mismatch, expected %0b, got %0b",
                             $time, oldest_match, m_matched);
                end
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #2_000_000;
        $display("Timeout after %0d items and %0d results", items_sent, results_seen);
        $display("FAIL");
        $finish;
    end

    initial begin
        int                    mode;
        int                    sel;
        int                    n;
        int                    sent;
        bit                    held;
        bit                    paused;
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [BYTE_W-1:0]     text;

        // Directed table. Expected values are spelled out where obvious,
        // the rest go through the row model.
        dir_tab = '{
            // straight after reset: empty pattern, length 0
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_YES},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'hFF, WANT_NO},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'hFF, WANT_YES},
            // "a*b"
            '{ROW_LOAD, 5'd3, 64'h0000_0000_0062_2A61, 64'h0, FUNC_START, 8'h00,
              WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_NO},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "b", WANT_YES},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "b", WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "a", WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "*", WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "b", WANT_PRED},
            // "*a": star in the first position only matches a literal '*'
            '{ROW_LOAD, 5'd2, 64'h0000_0000_0000_612A, 64'h0, FUNC_START, 8'h00,
              WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_NO},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "a", WANT_NO},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "*", WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "a", WANT_YES},
            // ".*", then an overlong length, then back: the row survives
            '{ROW_LOAD, 5'd2, 64'h0000_0000_0000_2A2E, 64'h0, FUNC_START, 8'h00,
              WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_YES},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'h00, WANT_YES},
            '{ROW_LOAD, 5'd31, 64'h0000_0000_0000_2A2E, 64'h0, FUNC_START, 8'h00,
              WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'hFF, WANT_PRED},
            '{ROW_LOAD, 5'd2, 64'h0000_0000_0000_2A2E, 64'h0, FUNC_START, 8'h00,
              WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "x", WANT_YES},
            // full 16 bytes "a*b*c*d*e*f*g*.*"
            '{ROW_LOAD, 5'd16, 64'h2A64_2A63_2A62_2A61, 64'h2A2E_2A67_2A66_2A65,
              FUNC_START, 8'h00, WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_YES},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'hFF, WANT_YES},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, "c", WANT_PRED},
            // byte extremes in the pattern: 0x00 then 0xFF
            '{ROW_LOAD, 5'd2, 64'h0000_0000_0000_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
              FUNC_START, 8'h00, WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_START, 8'h00, WANT_NO},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'h00, WANT_PRED},
            '{ROW_ITEM, 5'd0, 64'h0, 64'h0, FUNC_APPEND, 8'hFF, WANT_YES}
        };

        // hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, no idling
        for (int i = 0; i < $size(dir_tab); i++) begin
            if (dir_tab[i].kind == ROW_LOAD) begin
                wait_drain();
                set_pattern(dir_tab[i].len, dir_tab[i].lo, dir_tab[i].hi);
            end else begin
                send_item(dir_tab[i].item_func, dir_tab[i].text, dir_tab[i].want);
            end
        end

        // Random part: modes are no idling, sender idle, receiver stall, both.
        for (mode = 0; mode < 4; mode++) begin
            wait_drain();
            send_idle_pct  = (mode == 1) ? 58 : (mode == 3) ? 34 : 0;
            recv_stall_pct = (mode == 2) ? 58 : (mode == 3) ? 34 : 0;
            for (int k = 0; k < SETTINGS_PER_MODE; k++) begin
                wait_drain();
                // pattern bytes lean on 'a'..'c', '.' and '*' so that
                // sequences get deep into the row; a few are raw bytes
                for (int p = 0; p < BYTES_PER_WORD; p++) begin
                    for (int w = 0; w < 2; w++) begin
                        sel = $urandom_range(9);
                        if (sel < 2)       text = "a";
                        else if (sel == 2) text = "b";
                        else if (sel == 3) text = "c";
                        else if (sel < 6)  text = DOT_BYTE;
                        else if (sel < 9)  text = STAR_BYTE;
                        else               text = BYTE_W'($urandom_range(255));
                        if (w == 0) lo[BYTE_W*p +: BYTE_W] = text;
                        else        hi[BYTE_W*p +: BYTE_W] = text;
                    end
                end
                if ($urandom_range(9) == 0) begin
                    len = LEN_W'($urandom_range(31, PATTERN_MAX + 1));
                end else begin
                    len = LEN_W'($urandom_range(PATTERN_MAX));
                end
                // first setting of each mode is an extreme one
                if (k == 0) begin
                    case (mode)
                        0: len = '0;
                        1: len = LEN_W'(PATTERN_MAX);
                        2: begin
                            len = '1;
                            lo  = '1;
                            hi  = '1;
                        end
                        default: begin
                            len = LEN_W'(PATTERN_MAX);
                            lo  = '0;
                            hi  = '0;
                        end
                    endcase
                end
                set_pattern(len, lo, hi);

                sent   = 0;
                held   = 1'b0;
                paused = 1'b0;
                while (sent < ITEMS_PER_SETTING) begin
                    if (mode == 0 && k == 1 && !held && sent >= ITEMS_PER_SETTING / 2) begin
                        // Hold off the receiver for a long stretch and keep
                        // offering items: the result register fills and the
                        // input side has to stall.
                        s_valid <= 1'b0;
                        @(posedge aclk);
                        hold_req = 1'b1;
                        @(negedge aclk);
                        held = 1'b1;
                    end
                    if (mode == 1 && k == 1 && !paused && sent >= ITEMS_PER_SETTING / 2) begin
                        // pause the sender until the block has drained
                        wait_drain();
                        paused = 1'b1;
                    end
                    if ($urandom_range(9) == 0) begin
                        // noise: any function, any byte
                        send_item(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                                  WANT_PRED);
                        sent++;
                    end else begin
                        // well-formed text: a start, then a run of bytes
                        send_item(FUNC_START, BYTE_W'($urandom_range(255)), WANT_PRED);
                        n = $urandom_range(2 * effective_length() + 3);
                        repeat (n) begin
                            sel = $urandom_range(9);
                            if (sel < 5 && effective_length() > 0) begin
                                text = pattern_byte($urandom_range(effective_length() - 1));
                            end else if (sel < 8) begin
                                text = BYTE_W'("a" + $urandom_range(2));
                            end else if (sel == 8) begin
                                text = $urandom_range(1) ? STAR_BYTE : DOT_BYTE;
                            end else begin
                                text = BYTE_W'($urandom_range(255));
                            end
                            send_item(FUNC_APPEND, text, WANT_PRED);
                        end
                        sent += n + 1;
                    end
                end
            end
        end

        // all items offered: drain, then let the pipeline settle
        wait_drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d items over %0d pattern settings; %0d results checked, %0d matches.",
                 items_sent, settings_done, results_seen, matches_seen);
        $display("Idling modes, a long receiver hold-off and a sender pause were all run.");
        if (errors == 0 && pending_match_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors, %0d results still pending", errors, pending_match_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- wildcard_star_pattern_match_unit.f -----
sv/wsm_pkg.sv
sv/wsm_cell.sv
sv/wildcard_star_pattern_match_unit.sv
tb/tb_top.sv
